FILE: sv/bst_pkg.sv
// bst_pkg: shared types and constants for the bencode stream tokenizer
// no dependencies
package bst_pkg;

  localparam logic [2:0] KIND_INT    = 3'd0;
  localparam logic [2:0] KIND_SSTART = 3'd1;
  localparam logic [2:0] KIND_SBYTE  = 3'd2;
  localparam logic [2:0] KIND_LOPEN  = 3'd3;
  localparam logic [2:0] KIND_DOPEN  = 3'd4;
  localparam logic [2:0] KIND_CLOSE  = 3'd5;
  localparam logic [2:0] KIND_ERR    = 3'd6;

  localparam logic [3:0] ERR_NONE     = 4'd0;
  localparam logic [3:0] ERR_BAD_CHAR = 4'd1;
  localparam logic [3:0] ERR_NO_TERM  = 4'd2;
  localparam logic [3:0] ERR_EMPTY    = 4'd3;
  localparam logic [3:0] ERR_INT_LONG = 4'd4;
  localparam logic [3:0] ERR_LEN_LONG = 4'd5;
  localparam logic [3:0] ERR_END      = 4'd6;
  localparam logic [3:0] ERR_KEY      = 4'd7;
  localparam logic [3:0] ERR_DEEP     = 4'd8;

  localparam logic [1:0] ST_LIST = 2'd0;
  localparam logic [1:0] ST_DKEY = 2'd1;
  localparam logic [1:0] ST_DVAL = 2'd2;

  localparam logic [63:0] SAT_LIM = 64'h8000_0000_0000_0000;
  localparam logic [59:0] LEN_MASK = 60'hFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
    logic        is_key;
    logic [5:0]  depth;
    logic [3:0]  err;
    logic        done;
    logic        fin;
  } tok_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_t;

endpackage

FILE: sv/bst_fifo.sv
// bst_fifo: small two-entry queue carrying packed items between stages
// depends on nothing but its width parameter
module bst_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         empty
);
  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr && !full) mem_r[wp_r] <= wdata;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr && !full) wp_r <= ~wp_r;
      if (rd && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'((wr && !full) ? 1 : 0) - 2'((rd && !empty) ? 1 : 0);
    end
  end
endmodule

FILE: sv/bst_parse.sv
// bst_parse: back end, runs the bencode grammar on one byte per cycle while the token queue has room
// depends on bst_pkg; emits up to two tokens per byte into a token queue
module bst_parse #(
  parameter int MAX_DEPTH = 32,
  parameter int MAX_INT_CHARS = 30,
  parameter int MAX_LEN_DIGITS = 18
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  bst_pkg::byte_t in_b,
  output logic          in_take,
  output logic          t_push,
  output bst_pkg::tok_t t0,
  output logic          t_two,
  output bst_pkg::tok_t t1,
  input  logic          t_room
);
  localparam int DW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int LW = $clog2(MAX_DEPTH + 1);

  typedef enum logic [3:0] {
    M_VALUE = 4'b0001, M_INT = 4'b0010, M_LEN = 4'b0100, M_STR = 4'b1000
  } mode_t;
  typedef enum logic [2:0] {
    H_RUN = 3'b001, H_DONE = 3'b010, H_ERR = 3'b100
  } halt_t;

  logic [1:0]  stk_r [MAX_DEPTH];
  mode_t       mode_r, mode_nxt;
  halt_t       halt_r, halt_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        neg_r, neg_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [59:0] rem_r, rem_nxt;
  logic        sw;
  logic [DW-1:0] sa;
  logic [1:0]  sd;

  logic [7:0] b;
  logic       dig, has_top;
  logic [3:0] dv;
  logic [1:0] top;
  logic [DW-1:0] tix;
  logic [63:0] mul;
  logic [59:0] lmul;
  logic [59:0] rdec;
  logic        e0, done0;
  bst_pkg::tok_t r0;

  assign in_take = in_valid && t_room;
  assign b   = in_b.data;
  assign dig = b >= "0" && b <= "9";
  assign dv  = b[3:0];
  assign has_top = lvl_r != '0;
  assign tix = DW'(lvl_r - LW'(1));
  assign top = stk_r[tix];
  assign mul = (acc_r << 3) + (acc_r << 1) + 64'(dv);
  assign lmul = (rem_r << 3) + (rem_r << 1) + 60'(dv);
  assign rdec = rem_r - 60'd1;

  always_comb begin
    mode_nxt = mode_r; halt_nxt = halt_r; lvl_nxt = lvl_r;
    acc_nxt = acc_r; neg_nxt = neg_r; cnt_nxt = cnt_r; rem_nxt = rem_r;
    sw = 1'b0; sa = tix; sd = bst_pkg::ST_LIST;
    e0 = 1'b0; done0 = 1'b0;
    r0 = '0;
    r0.depth = 6'(lvl_r);
    t1 = '0;
    t1.kind = bst_pkg::KIND_ERR;
    t1.err  = bst_pkg::ERR_END;
    if (halt_r == H_RUN) begin
      case (mode_r)
        M_VALUE: begin
          if (has_top && top == bst_pkg::ST_DKEY && !(b == "e") && !dig) begin
            e0 = 1'b1; r0.kind = bst_pkg::KIND_ERR; r0.err = bst_pkg::ERR_KEY;
          end else if (b == "e" && has_top && top != bst_pkg::ST_DVAL) begin
            // close: pop then flip the parent if it is a dict
            lvl_nxt = lvl_r - LW'(1);
            e0 = 1'b1; r0.kind = bst_pkg::KIND_CLOSE; r0.depth = 6'(lvl_nxt);
            if (lvl_nxt == '0) begin
              halt_nxt = H_DONE; r0.done = 1'b1;
            end else begin
              sa = DW'(lvl_nxt - LW'(1));
              if (stk_r[sa] != bst_pkg::ST_LIST) begin
                sw = 1'b1;
                sd = (stk_r[sa] == bst_pkg::ST_DKEY) ? bst_pkg::ST_DVAL : bst_pkg::ST_DKEY;
              end
            end
          end else if (b == "i" && !(has_top && top == bst_pkg::ST_DKEY)) begin
            mode_nxt = M_INT; acc_nxt = '0; neg_nxt = 1'b0; cnt_nxt = '0;
          end else if ((b == "l" || b == "d") && !(has_top && top == bst_pkg::ST_DKEY)) begin
            e0 = 1'b1;
            if (lvl_r >= LW'(MAX_DEPTH)) begin
              r0.kind = bst_pkg::KIND_ERR; r0.err = bst_pkg::ERR_DEEP;
            end else begin
              r0.kind = (b == "l") ? bst_pkg::KIND_LOPEN : bst_pkg::KIND_DOPEN;
              sw = 1'b1; sa = DW'(lvl_r);
              sd = (b == "l") ? bst_pkg::ST_LIST : bst_pkg::ST_DKEY;
              lvl_nxt = lvl_r + LW'(1);
            end
          end else if (dig) begin
            mode_nxt = M_LEN; cnt_nxt = 5'd1; rem_nxt = 60'(dv);
          end else begin
            e0 = 1'b1; r0.kind = bst_pkg::KIND_ERR; r0.err = bst_pkg::ERR_BAD_CHAR;
          end
        end
        M_INT: begin
          if (b == "-" && cnt_r == '0) begin
            neg_nxt = 1'b1; cnt_nxt = 5'd1;
          end else if (dig) begin
            if (cnt_r >= 5'(MAX_INT_CHARS)) begin
              e0 = 1'b1; r0.kind = bst_pkg::KIND_ERR; r0.err = bst_pkg::ERR_INT_LONG;
            end else begin
              cnt_nxt = cnt_r + 5'd1;
              // saturate once above 2^63
              acc_nxt = (acc_r > 64'd922337203685477580 ||
                         (acc_r == 64'd922337203685477580 && dv > 4'd8)) ?
                        bst_pkg::SAT_LIM : mul;
            end
          end else if (cnt_r == '0 || (cnt_r == 5'd1 && neg_r)) begin
            e0 = 1'b1; r0.kind = bst_pkg::KIND_ERR; r0.err = bst_pkg::ERR_EMPTY;
          end else if (b == "e") begin
            e0 = 1'b1; r0.kind = bst_pkg::KIND_INT; done0 = 1'b1;
            r0.value = neg_r ? (64'd0 - acc_r) :
                       (acc_r[63] ? bst_pkg::SAT_LIM - 64'd1 : acc_r);
          end else begin
            e0 = 1'b1; r0.kind = bst_pkg::KIND_ERR; r0.err = bst_pkg::ERR_NO_TERM;
          end
        end
        M_LEN: begin
          if (dig) begin
            if (cnt_r >= 5'(MAX_LEN_DIGITS)) begin
              e0 = 1'b1; r0.kind = bst_pkg::KIND_ERR; r0.err = bst_pkg::ERR_LEN_LONG;
            end else begin
              cnt_nxt = cnt_r + 5'd1; rem_nxt = lmul & bst_pkg::LEN_MASK;
            end
          end else if (b == ":") begin
            e0 = 1'b1; r0.kind = bst_pkg::KIND_SSTART;
            r0.is_key = has_top && top == bst_pkg::ST_DKEY;
            r0.value = 64'(rem_r);
            if (rem_r == '0) done0 = 1'b1;
            else mode_nxt = M_STR;
          end else begin
            e0 = 1'b1; r0.kind = bst_pkg::KIND_ERR; r0.err = bst_pkg::ERR_NO_TERM;
          end
        end
        M_STR: begin
          e0 = 1'b1; r0.kind = bst_pkg::KIND_SBYTE; r0.value = 64'(b);
          r0.is_key = has_top && top == bst_pkg::ST_DKEY;
          rem_nxt = rdec;
          if (rdec == '0) done0 = 1'b1;
        end
        default: begin
          e0 = 1'b1; r0.kind = bst_pkg::KIND_ERR; r0.err = bst_pkg::ERR_BAD_CHAR;
        end
      endcase
      if (e0 && r0.kind == bst_pkg::KIND_ERR) halt_nxt = H_ERR;
      // value finished: flip dict phase or finish top level
      if (done0) begin
        mode_nxt = M_VALUE;
        if (!has_top) begin
          halt_nxt = H_DONE; r0.done = 1'b1;
        end else if (top != bst_pkg::ST_LIST) begin
          sw = 1'b1; sa = tix;
          sd = (top == bst_pkg::ST_DKEY) ? bst_pkg::ST_DVAL : bst_pkg::ST_DKEY;
        end
      end
    end
    t_two = in_b.last && halt_nxt == H_RUN;
    t_push = in_take && (e0 || t_two);
    r0.fin = !t_two;
    t1.depth = 6'(lvl_nxt);
    t1.fin = 1'b1;
    t0 = e0 ? r0 : t1;
    if (!e0) t_two = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_take && sw) stk_r[sa] <= sd;
    if (!rst_n) begin
      mode_r <= M_VALUE; halt_r <= H_RUN; lvl_r <= '0;
      acc_r <= '0; neg_r <= 1'b0; cnt_r <= '0; rem_r <= '0;
    end else if (in_take) begin
      if (in_b.last) begin
        mode_r <= M_VALUE; halt_r <= H_RUN; lvl_r <= '0;
        acc_r <= '0; neg_r <= 1'b0; cnt_r <= '0; rem_r <= '0;
      end else begin
        mode_r <= mode_nxt; halt_r <= halt_nxt; lvl_r <= lvl_nxt;
        acc_r <= acc_nxt; neg_r <= neg_nxt; cnt_r <= cnt_nxt; rem_r <= rem_nxt;
      end
    end
  end
endmodule

FILE: sv/bst_outq.sv
// bst_outq: result queue taking up to two tokens per cycle, one out per pop
// depends on bst_pkg
module bst_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bst_pkg::tok_t d0,
  input  logic          two,
  input  bst_pkg::tok_t d1,
  output logic          room,
  input  logic          pop,
  output bst_pkg::tok_t q,
  output logic          empty
);
  bst_pkg::tok_t mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       rd;

  assign room  = cnt_r <= 3'd2;
  assign empty = cnt_r == 3'd0;
  assign q     = mem_r[rp_r];
  assign rd    = pop && !empty;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= d0;
      if (two) mem_r[wp_r + 2'd1] <= d1;
    end
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + (two ? 2'd2 : 2'd1);
      if (rd) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + (push ? (two ? 3'd2 : 3'd1) : 3'd0) - (rd ? 3'd1 : 3'd0);
    end
  end
endmodule

FILE: sv/bencode_stream_tokenizer.sv
// bencode_stream_tokenizer: top level, byte queue, grammar engine, token queue
// depends on bst_pkg, bst_fifo, bst_parse, bst_outq
//
// Takes one bencode byte per clock while the input queue is not full and
// emits 0..2 tokens per byte through a queue interface. A byte is parsed as
// it leaves the two-entry input queue; the rate is one byte per cycle as
// long as the four-entry token queue keeps room for two tokens, so a byte
// that makes two tokens needs the consumer to pop twice. The first token of
// a byte goes into the token queue as the parser takes the byte and can then
// be popped. The nesting stack is a small register array, one entry per level.
module bencode_stream_tokenizer #(
  parameter int MAX_DEPTH = 32,
  parameter int MAX_INT_CHARS = 30,
  parameter int MAX_LEN_DIGITS = 18
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_in,
  input  logic        in_last_byte,
  input  logic        pop,
  output logic        empty,
  output logic [2:0]  out_token_kind,
  output logic signed [63:0] out_token_value,
  output logic        out_is_key,
  output logic [5:0]  out_nest_depth,
  output logic [3:0]  out_error_code,
  output logic        out_value_complete,
  output logic        out_final_of_run
);
  bst_pkg::byte_t ib, qb;
  logic qempty, take, tpush, ttwo, troom;
  bst_pkg::tok_t t0, t1, tq;

  assign ib.data = in_byte_in;
  assign ib.last = in_last_byte;

  bst_fifo #(.W($bits(bst_pkg::byte_t))) u_inq (
    .clk, .rst_n, .wr(push), .wdata(ib), .full,
    .rd(take), .rdata(qb), .empty(qempty)
  );

  bst_parse #(
    .MAX_DEPTH(MAX_DEPTH), .MAX_INT_CHARS(MAX_INT_CHARS),
    .MAX_LEN_DIGITS(MAX_LEN_DIGITS)
  ) u_parse (
    .clk, .rst_n, .in_valid(!qempty), .in_b(qb), .in_take(take),
    .t_push(tpush), .t0, .t_two(ttwo), .t1, .t_room(troom)
  );

  bst_outq u_outq (
    .clk, .rst_n, .push(tpush), .d0(t0), .two(ttwo), .d1(t1),
    .room(troom), .pop, .q(tq), .empty
  );

  assign out_token_kind     = tq.kind;
  assign out_token_value    = tq.value;
  assign out_is_key         = tq.is_key;
  assign out_nest_depth     = tq.depth;
  assign out_error_code     = tq.err;
  assign out_value_complete = tq.done;
  assign out_final_of_run   = tq.fin;

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_token_kind != bst_pkg::KIND_ERR |-> out_error_code == bst_pkg::ERR_NONE)
    else $error("error code on non-error token");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    tpush |-> troom)
    else $error("token push without room");
  a_two_push: assert property (@(posedge clk) disable iff (!rst_n)
    ttwo && tpush |-> t0.fin == 1'b0)
    else $error("second token without first");
endmodule
